// ===== design/rqts_pkg.sv =====
// Shared types, codes and default sizes for the ready-queue thread scheduler.
// Used by the scheduler top level and its port checker; depends on nothing.
package rqts_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned DEF_THREADS = 16;
  localparam int unsigned DEF_IDLE_ID = 1;

  // Fixed field widths of the stream payloads and the status store.
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned TID_W      = 4;
  localparam int unsigned BST_W      = 2;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned STATUS_W   = 3;

  // Per-slot thread status.
  typedef enum logic [STATUS_W-1:0] {
    ST_FREE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_WAITING = 3'd4,
    ST_HANGING = 3'd5
  } status_e;

  // Event kinds carried on the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 3'd0,
    KIND_PREEMPT = 3'd1,
    KIND_BLOCK   = 3'd2,
    KIND_UNBLOCK = 3'd3,
    KIND_YIELD   = 3'd4
  } kind_e;

  // Requested parking state for a block event.
  typedef enum logic [BST_W-1:0] {
    BST_BLOCKED = 2'd0,
    BST_WAITING = 2'd1,
    BST_HANGING = 2'd2
  } bst_e;

  // Result error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_NOT_BLOCKED = 2'd1,
    ERR_BUSY        = 2'd2,
    ERR_OVERFLOW    = 2'd3
  } err_e;

endpackage

// ===== design/ready_queue_thread_scheduler.sv =====
// Top level of the ready-queue thread scheduler: event sequencer, deque
// pointers and result register. Depends on rqts_pkg and rqts_ram.
//
//   Channel  | Dir | Handshake                        | Payload
//   ---------+-----+----------------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid_i / s_axis_tready_o | tuser: kind; tdata: tid, bst
//   m_axis   | out | m_axis_tvalid_o / m_axis_tready_i | tdata: sw, prev, next, error
//
// Each event runs through accept and memory read, then read-modify-write of
// the status and deque stores, then the second status write and the result load.
// The single write port of the status memory keeps the two status writes apart.
// A result that is not taken holds the sequencer in its last step.
// Reset is asynchronous and active low; the stores need no clearing pass.
module ready_queue_thread_scheduler
  import rqts_pkg::*;
#(
  parameter int unsigned THREADS = DEF_THREADS,
  parameter int unsigned IDLE_ID = DEF_IDLE_ID
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [3:0] thread_id, [5:4] block_state, [7:6] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] switched, [4:1] prev_thread, [8:5] next_thread, [10:9] error, [15:11] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IDW       = $clog2(THREADS);
  localparam int unsigned CW        = $clog2(THREADS + 1);
  localparam int unsigned SW        = IDW + 1;
  localparam int unsigned IDLE_SLOT = IDLE_ID % THREADS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB
  } state_e;

  state_e               state_q, state_d;
  kind_e                kind_q;
  logic [TID_W-1:0]     tid_q;
  logic [BST_W-1:0]     bst_q;
  logic [IDW-1:0]       head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [IDW-1:0]       run_q, run_d;
  logic [IDW-1:0]       prev_q;
  logic                 sw_q, sw_d;
  err_e                 err_q, err_d;
  logic                 resched_q, resched_d;
  logic [THREADS-1:0]   st_vld_q;
  logic                 slot0_init_q;
  logic                 rd_st_vld_q;
  logic [IDW-1:0]       rd_st_addr_q;
  logic                 rd_slot_init_q;
  logic                 m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Memory port signals.
  logic                 st_re, st_we;
  logic [IDW-1:0]       st_raddr, st_waddr;
  logic [STATUS_W-1:0]  st_wdata, st_rdata;
  logic                 sl_we;
  logic [IDW-1:0]       sl_waddr;
  logic [IDW-1:0]       sl_wdata, sl_rdata;

  // Execute-step write requests.
  logic                 x_st_we;
  logic [IDW-1:0]       x_st_waddr;
  status_e              x_st_wdata;

  // Decoded and derived values.
  kind_e                in_kind;
  logic [IDW-1:0]       in_tid_a;
  logic [IDW-1:0]       tid_a;
  logic                 tid_ok;
  logic                 full;
  logic [SW-1:0]        tail_sum;
  logic [IDW-1:0]       tail, head_inc, head_dec;
  status_e              st_rd;
  logic [IDW-1:0]       slot_rd;
  logic [CW-1:0]        cnt_push;
  logic                 cur_running;
  logic                 out_free;

  assign in_kind  = kind_e'(s_axis_tuser_i);
  assign in_tid_a = IDW'(s_axis_tdata_i[TID_W-1:0]);
  assign tid_a    = IDW'(tid_q);
  assign tid_ok   = 32'(tid_q) < 32'(THREADS);
  assign full     = count_q == CW'(THREADS);
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Circular deque index arithmetic.
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(THREADS)) ? IDW'(tail_sum - SW'(THREADS))
                                               : IDW'(tail_sum);
  assign head_inc = (head_q == IDW'(THREADS - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? IDW'(THREADS - 1) : head_q - 1'b1;

  // Read data with the reset contents filled in for never-written entries.
  always_comb begin
    if (rd_st_vld_q) begin
      st_rd = status_e'(st_rdata);
    end else if (rd_st_addr_q == '0) begin
      st_rd = ST_RUNNING;
    end else if (rd_st_addr_q == IDW'(IDLE_SLOT)) begin
      st_rd = ST_READY;
    end else begin
      st_rd = ST_FREE;
    end
  end

  assign slot_rd = rd_slot_init_q ? IDW'(IDLE_SLOT) : sl_rdata;

  // Read addresses are issued while waiting for an event.
  assign st_re    = state_q == S_IDLE;
  assign st_raddr = (in_kind == KIND_START || in_kind == KIND_UNBLOCK) ? in_tid_a : run_q;

  // Event execution: error checks, deque update and the first status write.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    run_d       = run_q;
    sw_d        = 1'b0;
    err_d       = ERR_OK;
    resched_d   = 1'b0;
    x_st_we     = 1'b0;
    x_st_waddr  = run_q;
    x_st_wdata  = ST_READY;
    sl_we       = 1'b0;
    sl_waddr    = tail;
    sl_wdata    = run_q;
    cur_running = st_rd == ST_RUNNING;
    cnt_push    = count_q + CW'(cur_running);
    case (kind_q)
      KIND_START: begin
        if (!tid_ok || st_rd != ST_FREE) begin
          err_d = ERR_BUSY;
        end else if (full) begin
          err_d = ERR_OVERFLOW;
        end else begin
          sl_we      = 1'b1;
          sl_wdata   = tid_a;
          x_st_we    = 1'b1;
          x_st_waddr = tid_a;
          count_d    = count_q + 1'b1;
        end
      end
      KIND_UNBLOCK: begin
        if (!tid_ok || !(st_rd inside {ST_BLOCKED, ST_WAITING, ST_HANGING})) begin
          err_d = ERR_NOT_BLOCKED;
        end else if (full) begin
          err_d = ERR_OVERFLOW;
        end else begin
          sl_we      = 1'b1;
          sl_waddr   = head_dec;
          sl_wdata   = tid_a;
          x_st_we    = 1'b1;
          x_st_waddr = tid_a;
          head_d     = head_dec;
          count_d    = count_q + 1'b1;
        end
      end
      KIND_PREEMPT, KIND_YIELD: begin
        if (cur_running && full) begin
          err_d = ERR_OVERFLOW;
        end else begin
          // Requeue the running thread at the back, then pop the head.
          sl_we     = cur_running;
          x_st_we   = cur_running;
          sw_d      = 1'b1;
          resched_d = 1'b1;
          if (cnt_push == '0) begin
            run_d = IDW'(IDLE_SLOT);
          end else begin
            run_d   = (count_q == '0) ? run_q : slot_rd;
            head_d  = head_inc;
            count_d = cnt_push - 1'b1;
          end
        end
      end
      KIND_BLOCK: begin
        // Park the running thread; fall back to the idle thread on empty.
        x_st_we = 1'b1;
        case (bst_q)
          BST_WAITING: x_st_wdata = ST_WAITING;
          BST_HANGING: x_st_wdata = ST_HANGING;
          default:     x_st_wdata = ST_BLOCKED;
        endcase
        sw_d      = 1'b1;
        resched_d = 1'b1;
        if (count_q == '0) begin
          run_d = IDW'(IDLE_SLOT);
        end else begin
          run_d   = slot_rd;
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Status write port: first write in execute, the running mark in writeback.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = x_st_waddr;
    st_wdata = x_st_wdata;
    case (state_q)
      S_EXEC: begin
        st_we = x_st_we;
      end
      S_WB: begin
        st_we    = resched_q;
        st_waddr = run_q;
        st_wdata = ST_RUNNING;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer state, deque pointers and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= CW'((IDLE_SLOT != 0) ? 1 : 0);
      run_q        <= '0;
      st_vld_q     <= '0;
      slot0_init_q <= 1'b1;
      resched_q    <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (sl_we && state_q == S_EXEC && sl_waddr == '0) begin
        slot0_init_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        head_q    <= head_d;
        count_q   <= count_d;
        run_q     <= run_d;
        resched_q <= resched_d;
      end
      // A new result replaces the one taken in the same cycle.
      if (state_q == S_WB && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: captured event, read metadata, result word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      kind_q         <= in_kind;
      tid_q          <= s_axis_tdata_i[TID_W-1:0];
      bst_q          <= s_axis_tdata_i[TID_W+BST_W-1:TID_W];
      rd_st_addr_q   <= st_raddr;
      rd_st_vld_q    <= st_vld_q[st_raddr];
      rd_slot_init_q <= slot0_init_q && (head_q == '0);
      prev_q         <= run_q;
    end
    if (state_q == S_EXEC) begin
      sw_q  <= sw_d;
      err_q <= err_d;
    end
    if (state_q == S_WB && out_free) begin
      m_data_q <= {5'b0, err_q, TID_W'(run_q), TID_W'(prev_q), sw_q};
    end
  end

  // Thread status store.
  rqts_ram #(
    .WIDTH (STATUS_W),
    .DEPTH (THREADS)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Ready deque store.
  rqts_ram #(
    .WIDTH (IDW),
    .DEPTH (THREADS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we && state_q == S_EXEC),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (st_re),
    .raddr_i (head_q),
    .rdata_o (sl_rdata)
  );

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== design/rqts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; instanced by the scheduler for the status and deque stores.
module rqts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rqts_checker.sv =====
// Port-level checker for the ready-queue thread scheduler, bound to the top.
// Depends on rqts_pkg for payload widths and error codes.
module rqts_checker
  import rqts_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [KIND_W-1:0]     s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // An error result never reports a thread switch.
  a_err_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[10:9] != ERR_OK) |-> !m_axis_tdata_o[0])
    else $error("switch reported together with an error");

  // Without a switch the running thread is unchanged.
  a_no_switch_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[8:5] == m_axis_tdata_o[4:1])
    else $error("next thread differs without a switch");

  // Events are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("new event taken while one is in progress");

endmodule

bind ready_queue_thread_scheduler rqts_checker u_rqts_checker (.*);
